@@ hdl/bee_pkg.sv @@
// ----------------------------------------------------------------------------
// bee_pkg: shared types and constants for the byte entropy estimator
// Holds the transaction structs, histogram geometry and fixed-point limits.
// ----------------------------------------------------------------------------
package bee_pkg;

  localparam int NUM_BINS  = 256;
  localparam int BIN_AW    = 8;
  localparam int LOG_FRAC  = 30;
  localparam logic [19:0] ENT_MAX = 20'd524288;

  typedef struct packed {
    logic [7:0] sample;
    logic       is_last;
  } bee_in_t;

  typedef struct packed {
    logic [19:0] shannon_bits;
    logic [19:0] min_entropy_bits;
    logic [8:0]  distinct_values;
    logic [14:0] set_size;
    logic        overflowed;
  } bee_out_t;

  // log2 unit control
  typedef struct packed {
    logic        start;
    logic [31:0] arg;
  } bee_log_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [35:0] result;
  } bee_log_rsp_t;

endpackage

@@ hdl/bee_log2.sv @@
// ----------------------------------------------------------------------------
// bee_log2: iterative log2 in Q30
// Normalizes one bit a cycle, then 30 squaring steps on a split multiplier.
// ----------------------------------------------------------------------------
module bee_log2 (
  input  logic                  clk,
  input  logic                  rst,
  input  bee_pkg::bee_log_req_t req,
  output bee_pkg::bee_log_rsp_t rsp
);
  import bee_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_MLO  = 3'd2;
  localparam logic [2:0] S_MHI  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state;
  logic [31:0] x;
  logic [4:0]  e;
  logic [30:0] m;      // Q30 mantissa in [1,2)
  logic [29:0] frac;
  logic [4:0]  step;
  logic [61:0] plo;    // m * m[15:0]
  logic [61:0] prod;

  // mantissa from the original argument once normalized
  logic [31:0] arg_hold;
  logic [61:0] mfull;
  logic [30:0] m_init;

  // m*m split in two halves of the low operand
  logic [46:0] part;
  assign part = 47'(m) * 47'(state == S_MLO ? {1'b0, m[15:0]} : {2'b0, m[30:16]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req.start) begin
          x     <= req.arg;
          e     <= '0;
          frac  <= '0;
          step  <= '0;
          state <= (req.arg == 32'd0) ? S_DONE : S_NORM;
        end
        S_NORM: begin
          if (x[31:1] != 31'd0) begin
            x <= x >> 1;
            e <= e + 5'd1;
          end else begin
            m     <= m_init;
            state <= S_MLO;
          end
        end
        S_MLO: begin
          plo   <= {15'd0, part};
          state <= S_MHI;
        end
        S_MHI: begin
          prod  <= plo + ({15'd0, part} << 16);
          state <= S_FIX;
        end
        S_FIX: begin
          if (prod[61]) begin
            m    <= prod[61:31];
            frac <= {frac[28:0], 1'b1};
          end else begin
            m    <= prod[60:30];
            frac <= {frac[28:0], 1'b0};
          end
          step  <= step + 5'd1;
          state <= (step == 5'(LOG_FRAC - 1)) ? S_DONE : S_MLO;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.start) arg_hold <= req.arg;
  end

  // mantissa load takes the leading one and the bits below it
  assign mfull  = {30'd0, arg_hold} << LOG_FRAC;
  assign m_init = 31'(mfull >> e);

  assign rsp.busy   = (state != S_IDLE);
  assign rsp.done   = (state == S_DONE);
  assign rsp.result = (arg_hold == 32'd0) ? 36'd0 : {1'b0, e, frac};
endmodule

@@ hdl/byte_entropy_estimator.sv @@
// ----------------------------------------------------------------------------
// byte_entropy_estimator: Shannon and min-entropy of a byte sample set
// Histograms samples, then walks all bins with one shared log2 unit.
// ----------------------------------------------------------------------------
//  channel | dir | payload   | handshake
//  in      | in  | bee_in_t  | in_valid / in_ready
//  out     | out | bee_out_t | out_valid / out_ready
//
// Each sample passes through accept, bin read and bin write; a new sample is
// taken only after the last one is written. The closing pass reads every bin,
// runs a log2 and a multiply for each nonzero bin, then two more log2 runs
// (set size, largest bin), a restoring divide and the output register load.
// After reset a clearing pass over all bins runs before the first transaction;
// the closing pass clears each bin as it reads it. in_ready is low meanwhile.
// A finished result waits in the output register until out_ready.
module byte_entropy_estimator #(
  parameter int MAX_SAMPLES = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bee_pkg::bee_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bee_pkg::bee_out_t out_data
);
  import bee_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_WR    = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_WDATA = 4'd5;
  localparam logic [3:0] S_WLOG  = 4'd6;
  localparam logic [3:0] S_WMUL  = 4'd7;
  localparam logic [3:0] S_NLOG  = 4'd8;
  localparam logic [3:0] S_MLOG  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_WSET  = 4'd12;

  logic [3:0]        state;
  logic [CW-1:0]     mem [NUM_BINS];
  logic [CW-1:0]     rd_q;
  logic [BIN_AW-1:0] idx;
  logic [7:0]        cur;
  logic [CW-1:0]     n, maxc;
  logic [CW-1:0]     cnt;       // count of the bin under log2
  logic [8:0]        distinct;
  logic              over, last_q;
  logic [63:0]       sum;
  logic [35:0]       ln, lmax, lc;
  logic [63:0]       num;
  logic [63:0]       den, rem;
  logic [19:0]       quo;
  logic              qhi;       // quotient reached bit 20 or above
  logic [6:0]        dstep;
  logic              go;
  logic [31:0]       log_arg;

  bee_log_req_t lreq;
  bee_log_rsp_t lrsp;

  bee_log2 u_log (.clk(clk), .rst(rst), .req(lreq), .rsp(lrsp));

  // RAM: one write, one registered read
  logic              we;
  logic [7:0]        waddr, raddr;
  logic [CW-1:0]     wdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_comb begin
    we = 1'b0; waddr = cur; wdata = '0; raddr = cur;
    unique case (state)
      S_CLR:  begin we = 1'b1; waddr = idx; end
      S_WR:   begin we = 1'b1; wdata = rd_q + CW'(1); end
      S_WRD:  raddr = idx;
      S_WDATA: begin we = 1'b1; waddr = idx; end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign lreq.start = go;
  assign lreq.arg   = log_arg;

  logic [CW-1:0] n_inc;
  assign n_inc = n + CW'(1);

  // Shannon: (n*ln - sum) / (n << 14), rounded half up; restoring divide
  logic [63:0] tot;
  assign tot = 64'(n) * 64'(ln);

  logic [63:0] trial;
  assign trial = {rem[62:0], num[63]};

  logic [35:0] mdiff;
  assign mdiff = ln - lmax + 36'd8192;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; idx <= '0; n <= '0; out_valid <= 1'b0; go <= 1'b0;
    end else begin
      go <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          idx <= idx + BIN_AW'(1);
          if (idx == '1) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          cur <= in_data.sample; last_q <= in_data.is_last;
          n <= n_inc;
          state <= S_RD;
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (last_q || n >= CW'(MAX_SAMPLES)) begin
            over <= !last_q;
            idx <= '0; sum <= '0; maxc <= '0; distinct <= '0;
            state <= S_WRD;
          end else state <= S_IDLE;
        end
        S_WRD: state <= S_WDATA;
        S_WDATA: begin
          if (rd_q != '0) begin
            distinct <= distinct + 9'd1;
            if (rd_q > maxc) maxc <= rd_q;
            cnt <= rd_q;
            go <= 1'b1; log_arg <= 32'(rd_q);
            state <= S_WLOG;
          end else if (idx == '1) begin
            go <= 1'b1; log_arg <= 32'(n); state <= S_NLOG;
          end else begin
            idx <= idx + BIN_AW'(1); state <= S_WRD;
          end
        end
        S_WLOG: if (lrsp.done) begin
          lc <= lrsp.result; state <= S_WMUL;
        end
        S_WMUL: begin
          sum <= sum + 64'(cnt) * 64'(lc);
          if (idx == '1) begin
            go <= 1'b1; log_arg <= 32'(n); state <= S_NLOG;
          end else begin
            idx <= idx + BIN_AW'(1); state <= S_WRD;
          end
        end
        S_NLOG: if (lrsp.done) begin
          ln <= lrsp.result; go <= 1'b1; log_arg <= 32'(maxc); state <= S_MLOG;
        end
        S_MLOG: if (lrsp.done) begin
          lmax <= lrsp.result;
          num <= (sum >= tot) ? 64'd0 : (tot - sum + (64'(n) << 13));
          den <= 64'(n) << 14;
          rem <= '0; dstep <= '0; quo <= '0; qhi <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          num <= num << 1;
          // quotient bits above 19 only matter for saturation
          if (trial >= den) begin
            rem <= trial - den;
            if (dstep >= 7'd44) quo <= {quo[18:0], 1'b1};
            else qhi <= 1'b1;
          end else begin
            rem <= trial;
            if (dstep >= 7'd44) quo <= {quo[18:0], 1'b0};
          end
          dstep <= dstep + 7'd1;
          if (dstep == 7'd63) state <= S_OUT;
        end
        S_OUT: begin
          out_data.shannon_bits <= (qhi || quo > ENT_MAX) ? ENT_MAX : quo;
          out_data.min_entropy_bits <= (lmax >= ln) ? 20'd0 :
            ((mdiff >> 14) > 36'(ENT_MAX)) ? ENT_MAX : 20'(mdiff >> 14);
          out_data.distinct_values <= distinct;
          out_data.set_size <= 15'(n);
          out_data.overflowed <= over;
          out_valid <= 1'b1;
          n <= '0;
          state <= S_WSET;
        end
        S_WSET: if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ test/byte_entropy_estimator_test.sv @@
// ----------------------------------------------------------------------------
// byte_entropy_estimator_test: self-checking bench for the entropy estimator
// Streams byte sample sets through the block and compares every result
// transaction with a local fixed-point histogram and entropy calculation.
// ----------------------------------------------------------------------------
module byte_entropy_estimator_test;
  import bee_pkg::*;

  localparam int MAX_SAMPLES = 16384;
  localparam int TAIL_CYCLES = 30000;   // covers a full closing pass

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bee_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bee_out_t out_data;

  byte_entropy_estimator #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Stimulus, predicted results and bookkeeping
  bee_in_t     pending_samples[$];
  bee_out_t    expected_sets[$];
  idle_mode_t  idle_mode = IDLE_NONE;
  int          error_count = 0;
  logic        in_took = 1'b0;

  // Local histogram mirrors the block's state
  int unsigned hist[NUM_BINS];
  int unsigned hist_total = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // log2 in Q30, integer part from the top set bit, fraction by repeated squaring
  function automatic bit [63:0] log2_fix(bit [31:0] x);
    bit [63:0] m;
    bit [63:0] frac;
    int unsigned e;
    frac = 0;
    e = 0;
    if (x == 0) return 64'd0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = ({32'd0, x} << LOG_FRAC) >> e;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> LOG_FRAC;
      frac = frac << 1;
      if (m >= (64'd2 << LOG_FRAC)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  // Walk the histogram, form both entropies, then clear it
  function automatic bee_out_t close_set(bit over);
    bee_out_t  r;
    bit [63:0] n, ln, sum, tot, sh, mn, lmax, d;
    int unsigned maxc, distinct;
    n = hist_total;
    ln = log2_fix(hist_total);
    sum = 0;
    maxc = 0;
    distinct = 0;
    for (int i = 0; i < NUM_BINS; i++) begin
      if (hist[i] != 0) begin
        distinct++;
        if (hist[i] > maxc) maxc = hist[i];
        sum += 64'(hist[i]) * log2_fix(hist[i]);
      end
    end
    tot = n * ln;
    if (n == 0 || sum >= tot) sh = 0;  // truncation can leave a tiny negative
    else begin
      d = n << (LOG_FRAC - 16);
      sh = (tot - sum + (d >> 1)) / d;
    end
    if (sh > ENT_MAX) sh = ENT_MAX;
    lmax = log2_fix(maxc);
    if (lmax >= ln) mn = 0;
    else mn = (ln - lmax + (64'd1 << (LOG_FRAC - 17))) >> (LOG_FRAC - 16);
    if (mn > ENT_MAX) mn = ENT_MAX;
    r.shannon_bits     = sh[19:0];
    r.min_entropy_bits = mn[19:0];
    r.distinct_values  = distinct[8:0];
    r.set_size         = n[14:0];
    r.overflowed       = over;
    foreach (hist[i]) hist[i] = 0;
    hist_total = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic bit sender_gap();
    if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 64;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 13;
    return 1'b0;
  endfunction

  function automatic bit receiver_stall();
    if (idle_mode == IDLE_RECEIVER) return $urandom_range(99) < 64;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 13;
    return 1'b0;
  endfunction

  // Driver: inputs change on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // valid stays up with the same payload until the transaction is taken
      if (!in_valid || in_took) begin
        if (pending_samples.size() > 0 && !sender_gap()) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !receiver_stall();
    end
  end

  // Monitor: sample handshakes on the rising edge, predict and check
  always @(posedge clk) begin
    bee_out_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        hist[in_data.sample]++;
        hist_total++;
        // a last mark wins over reaching the sample limit
        if (in_data.is_last) expected_sets.push_back(close_set(1'b0));
        else if (hist_total >= MAX_SAMPLES) expected_sets.push_back(close_set(1'b1));
      end
      if (out_valid && out_ready) begin
        if (expected_sets.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = expected_sets.pop_front();
          if (out_data.shannon_bits !== want.shannon_bits)
            report_mismatch("shannon_bits", out_data.shannon_bits, want.shannon_bits);
          if (out_data.min_entropy_bits !== want.min_entropy_bits)
            report_mismatch("min_entropy_bits", out_data.min_entropy_bits,
                            want.min_entropy_bits);
          if (out_data.distinct_values !== want.distinct_values)
            report_mismatch("distinct_values", out_data.distinct_values,
                            want.distinct_values);
          if (out_data.set_size !== want.set_size)
            report_mismatch("set_size", out_data.set_size, want.set_size);
          if (out_data.overflowed !== want.overflowed)
            report_mismatch("overflowed", out_data.overflowed, want.overflowed);
        end
      end
    end
  end

  task automatic push_sample(int s, bit last);
    bee_in_t t;
    t.sample = s[7:0];
    t.is_last = last;
    pending_samples.push_back(t);
  endtask

  // One random set; small sizes, sometimes a narrow alphabet for skewed bins
  task automatic push_random_set();
    int len, alpha, base;
    len = ($urandom_range(9) == 0) ? $urandom_range(300, 60) : $urandom_range(30, 1);
    alpha = $urandom_range(3) == 0 ? $urandom_range(4, 1) : 256;
    base = $urandom_range(255);
    for (int i = 0; i < len; i++) begin
      if (alpha == 256) push_sample($urandom_range(255), i == len - 1);
      else push_sample((base + $urandom_range(alpha - 1)) % 256, i == len - 1);
    end
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_sets.size() > 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    foreach (hist[i]) hist[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-sample sets at the byte extremes
    push_sample(0, 1'b1);
    push_sample(255, 1'b1);
    // same value repeated: zero entropy
    for (int i = 0; i < 4; i++) push_sample(8'hA5, i == 3);
    // two equal halves: exactly one bit
    push_sample(8'h00, 1'b0);
    push_sample(8'hFF, 1'b1);
    // skewed three-sample set
    push_sample(8'h55, 1'b0);
    push_sample(8'h55, 1'b0);
    push_sample(8'hAA, 1'b1);
    drain();
    // all 256 values once: entropy at its top of 8 bits
    for (int i = 0; i < 256; i++) push_sample(i, i == 255);
    drain();

    // Random sets across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_t'(ph);
      while (pending_samples.size() < 165) push_random_set();
      drain();
    end
    idle_mode = IDLE_NONE;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_sets.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
